@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helper macros, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`endif
`endif

@@ design/esd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants of the escape sequence decoder
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int MAX_HEX_DIGITS = 8;
  localparam int MAX_OCT_DIGITS = 11;
  localparam int QUEUE_DEPTH    = 4;

  // widest result list of one character: octal replay of eleven digits
  localparam int CMD_BYTES = 13;
  localparam int NB_W      = 4;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X_LO      = 8'h78;
  localparam logic [7:0] CH_X_UP      = 8'h58;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } char_t;

  typedef struct packed {
    logic [31:0] code;
    logic        final_res;
  } code_t;

  typedef struct packed {
    logic                          has_word;
    logic [31:0]                   word;
    logic [NB_W-1:0]               nbytes;
    logic [CMD_BYTES-1:0][7:0]     bytes;
    logic                          last_word;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_push_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

@@ design/esd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_front
// accepts characters, tracks escape state and digits, pushes result lists
// ----------------------------------------------------------------------------
module esd_front #(
  parameter int MAX_HEX_DIGITS = esd_pkg::MAX_HEX_DIGITS,
  parameter int MAX_OCT_DIGITS = esd_pkg::MAX_OCT_DIGITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             char_valid,
  output logic             char_stall,
  input  esd_pkg::char_t   char_word,
  input  logic             full,
  output esd_pkg::q_push_t push
);

  localparam int BUF_DEPTH = (MAX_OCT_DIGITS > MAX_HEX_DIGITS) ? MAX_OCT_DIGITS
                                                               : MAX_HEX_DIGITS;
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ESC   = 2'd1;
  localparam logic [1:0] MODE_HEX   = 2'd2;
  localparam logic [1:0] MODE_OCT   = 2'd3;

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] ctrl_map(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      default: r = c;
    endcase
    return r;
  endfunction

  logic [1:0]       mode, mode_next;
  logic [31:0]      accum, accum_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  logic [7:0]       x_letter, x_letter_next;
  logic [7:0]       digit_buffer [BUF_DEPTH];

  logic             accept, emit, tail, wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic [4:0]       hexd;
  logic             is_bs, is_x, is_oct, eot;
  logic [7:0]       ch;
  esd_pkg::cmd_t    cmd;

  assign char_stall = full;

  always_comb begin
    ch     = char_word.ch;
    eot    = char_word.end_of_text;
    hexd   = hex_digit(ch);
    is_bs  = ch == esd_pkg::CH_BACKSLASH;
    is_x   = ch == esd_pkg::CH_X_LO || ch == esd_pkg::CH_X_UP;
    is_oct = ch >= esd_pkg::CH_ZERO && ch <= esd_pkg::CH_SEVEN;
    accept = char_valid && !full;

    mode_next        = mode;
    accum_next       = accum;
    digit_count_next = digit_count;
    x_letter_next    = x_letter;
    wr_en            = 1'b0;
    wr_idx           = digit_count[IDX_W-1:0];
    emit             = 1'b0;
    tail             = 1'b0;
    cmd              = '0;

    unique case (mode)
      MODE_PLAIN: begin
        tail = 1'b1;
      end
      MODE_ESC: begin
        accum_next       = '0;
        digit_count_next = '0;
        if (is_x) begin
          x_letter_next = ch;
          mode_next     = MODE_HEX;
          cmd.bytes[0]  = esd_pkg::CH_BACKSLASH;
          cmd.bytes[1]  = ch;
          cmd.nbytes    = esd_pkg::NB_W'(2);
          emit          = eot;
        end else if (is_oct) begin
          wr_en            = 1'b1;
          wr_idx           = '0;
          digit_count_next = CNT_W'(1);
          accum_next       = {29'b0, ch[2:0]};
          mode_next        = MODE_OCT;
          cmd.has_word     = 1'b1;
          cmd.word         = {29'b0, ch[2:0]};
          emit             = eot;
        end else begin
          cmd.bytes[0] = ctrl_map(ch);
          cmd.nbytes   = esd_pkg::NB_W'(1);
          emit         = 1'b1;
          mode_next    = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (hexd[4]) begin
          if (digit_count >= CNT_W'(MAX_HEX_DIGITS)) begin
            cmd.bytes[0] = esd_pkg::CH_BACKSLASH;
            cmd.bytes[1] = x_letter;
            for (int k = 0; k < MAX_HEX_DIGITS; k++) cmd.bytes[k+2] = digit_buffer[k];
            cmd.bytes[MAX_HEX_DIGITS+2] = ch;
            cmd.nbytes       = esd_pkg::NB_W'(MAX_HEX_DIGITS + 3);
            emit             = 1'b1;
            mode_next        = MODE_PLAIN;
            digit_count_next = '0;
            accum_next       = '0;
          end else begin
            wr_en            = 1'b1;
            digit_count_next = digit_count + CNT_W'(1);
            accum_next       = {accum[27:0], hexd[3:0]};
            cmd.has_word     = 1'b1;
            cmd.word         = {accum[27:0], hexd[3:0]};
            emit             = eot;
          end
        end else begin
          if (digit_count != '0) begin
            cmd.has_word = 1'b1;
            cmd.word     = accum;
          end else begin
            cmd.bytes[0] = esd_pkg::CH_BACKSLASH;
            cmd.bytes[1] = x_letter;
            cmd.nbytes   = esd_pkg::NB_W'(2);
          end
          emit      = 1'b1;
          mode_next = MODE_PLAIN;
          tail      = 1'b1;
        end
      end
      default: begin
        if (is_oct) begin
          if (digit_count >= CNT_W'(MAX_OCT_DIGITS)) begin
            cmd.bytes[0] = esd_pkg::CH_BACKSLASH;
            for (int k = 0; k < MAX_OCT_DIGITS; k++) cmd.bytes[k+1] = digit_buffer[k];
            cmd.bytes[MAX_OCT_DIGITS+1] = ch;
            cmd.nbytes       = esd_pkg::NB_W'(MAX_OCT_DIGITS + 2);
            emit             = 1'b1;
            mode_next        = MODE_PLAIN;
            digit_count_next = '0;
            accum_next       = '0;
          end else begin
            wr_en            = 1'b1;
            digit_count_next = digit_count + CNT_W'(1);
            accum_next       = {accum[28:0], ch[2:0]};
            cmd.has_word     = 1'b1;
            cmd.word         = {accum[28:0], ch[2:0]};
            emit             = eot;
          end
        end else begin
          cmd.has_word = 1'b1;
          cmd.word     = accum;
          emit         = 1'b1;
          mode_next    = MODE_PLAIN;
          tail         = 1'b1;
        end
      end
    endcase

    // ending character handled as plain text, or as the start of a new escape if it is a backslash
    if (tail) begin
      if (is_bs && !eot) begin
        mode_next = MODE_ESC;
      end else begin
        cmd.bytes[cmd.nbytes] = ch;
        cmd.nbytes            = cmd.nbytes + esd_pkg::NB_W'(1);
        emit                  = 1'b1;
        mode_next             = MODE_PLAIN;
      end
    end

    if (eot) mode_next = MODE_PLAIN;
    cmd.last_word = eot;

    push.valid = accept && emit;
    push.cmd   = cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PLAIN;
      accum       <= '0;
      digit_count <= '0;
      x_letter    <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      accum       <= accum_next;
      digit_count <= digit_count_next;
      x_letter    <= x_letter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) digit_buffer[wr_idx] <= ch;
  end

endmodule

@@ design/esd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_queue
// small fifo of result lists between the front and the back
// ----------------------------------------------------------------------------
module esd_queue #(
  parameter int DEPTH = esd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::q_push_t push,
  output logic             full,
  output esd_pkg::q_head_t head,
  input  logic             pop
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  esd_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = count == CNT_W'(DEPTH);
  assign head.valid = count != '0;
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) entries[wr_ptr] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.valid) - CNT_W'(pop);
    end
  end

endmodule

@@ design/esd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_back
// walks the head result list and sends one code per cycle when not stalled
// ----------------------------------------------------------------------------
module esd_back (
  input  logic             clk,
  input  logic             rst,
  input  esd_pkg::q_head_t head,
  output logic             pop,
  output logic             code_valid,
  input  logic             code_stall,
  output esd_pkg::code_t   code_word
);

  logic [esd_pkg::NB_W-1:0] pos, total, bidx;
  logic                     load, last;
  esd_pkg::code_t           item;

  always_comb begin
    total = esd_pkg::NB_W'(head.cmd.has_word) + head.cmd.nbytes;
    last  = pos == total - esd_pkg::NB_W'(1);
    bidx  = pos - esd_pkg::NB_W'(head.cmd.has_word);
    if (head.cmd.has_word && pos == '0) item.code = head.cmd.word;
    else item.code = {24'b0, head.cmd.bytes[bidx]};
    item.final_res = head.cmd.last_word && last;
    load = head.valid && (!code_valid || !code_stall);
    pop  = load && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      pos        <= '0;
    end else if (load) begin
      code_valid <= 1'b1;
      pos        <= last ? '0 : pos + esd_pkg::NB_W'(1);
    end else if (!code_stall) begin
      code_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) code_word <= item;
  end

endmodule

@@ design/escape_sequence_decoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder_top
// decodes c style escapes in a character stream into 32-bit code values
//
// char channel: one character and its end-of-text mark per word, taken on
// any cycle with char_valid high and char_stall low
// code channel: one decoded value per word, final_res set on the last value
// of a string
// a character is classified in the cycle it is taken; its first code reaches
// the code channel through the queue and then the output register
// throughput: one character per cycle unless char_stall is high; the back
// end sends one code per cycle unless code_stall is high, so a malformed escape
// that replays its text ties up the single output register walking the list
// the queue between the two halves holds QUEUE_DEPTH result lists; char_stall
// rises only when it is full, so a stalled receiver backs up into it first
// reset clears the escape state, empties the queue and drops code_valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escape_sequence_decoder_top #(
  parameter int MAX_HEX_DIGITS = esd_pkg::MAX_HEX_DIGITS,
  parameter int MAX_OCT_DIGITS = esd_pkg::MAX_OCT_DIGITS,
  parameter int QUEUE_DEPTH    = esd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           char_valid,
  output logic           char_stall,
  input  esd_pkg::char_t char_word,
  output logic           code_valid,
  input  logic           code_stall,
  output esd_pkg::code_t code_word
);

  esd_pkg::q_push_t q_push;
  esd_pkg::q_head_t q_head;
  logic             q_full;
  logic             q_pop;

  esd_front #(
    .MAX_HEX_DIGITS(MAX_HEX_DIGITS),
    .MAX_OCT_DIGITS(MAX_OCT_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .char_valid(char_valid),
    .char_stall(char_stall),
    .char_word (char_word),
    .full      (q_full),
    .push      (q_push)
  );

  esd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk (clk),
    .rst (rst),
    .push(q_push),
    .full(q_full),
    .head(q_head),
    .pop (q_pop)
  );

  esd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .pop       (q_pop),
    .code_valid(code_valid),
    .code_stall(code_stall),
    .code_word (code_word)
  );

  `ASSERT_NEVER(a_push_full, clk, rst, q_push.valid && q_full, "push into full queue")
  `ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && !q_head.valid, "pop from empty queue")
  `ASSERT_IMPLIES(a_reset_out, clk, rst, $past(rst), !code_valid && !q_head.valid, "not idle after reset")

endmodule
